[rtl/hvd_pkg.sv]
package hvd_pkg;

    localparam int CORDIC_STEPS_DEF = 32;

    // angle / CORDIC datapath width, Q30 with headroom
    localparam int ANG_W = 34;

    // digit-by-digit square root: one bit of root per step, radicand below 2^62
    localparam int SQ_STEPS = 31;
    localparam int SQ_W     = 62;

    localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 34'sd6746518852;
    localparam logic signed [ANG_W-1:0] INV_GAIN    = 34'sd652032874;

    // pi/180 in Q40, split at bit 20
    localparam logic [14:0] K_DEG_HI = 15'd18301;
    localparam logic [19:0] K_DEG_LO = 20'd108693;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    localparam logic [29:0] RADIUS_RST = 30'd637279756;

    typedef struct packed {
        logic signed [ANG_W-1:0] x;
        logic signed [ANG_W-1:0] y;
        logic signed [ANG_W-1:0] z;
    } t_cordic;

    // atan(2^-i) in Q30
    function automatic logic signed [ANG_W-1:0] f_atan(input int unsigned i);
        logic signed [ANG_W-1:0] res;
        case (i)
            0:       res = 34'sd843314857;
            1:       res = 34'sd497837829;
            2:       res = 34'sd263043837;
            3:       res = 34'sd133525159;
            4:       res = 34'sd67021687;
            5:       res = 34'sd33543516;
            6:       res = 34'sd16775851;
            7:       res = 34'sd8388437;
            8:       res = 34'sd4194283;
            9:       res = 34'sd2097149;
            default: begin
                if (i <= 30) begin
                    res = ANG_W'(64'd1 << (30 - i));
                end else if (i == 31) begin
                    res = 34'sd1;
                end else begin
                    res = '0;
                end
            end
        endcase
        return res;
    endfunction

endpackage

[rtl/hvd_cordic_cell.sv]
module hvd_cordic_cell #(
    parameter int unsigned STEP   = 0,
    parameter bit          VECTOR = 1'b0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  hvd_pkg::t_cordic i_data,
    input  logic             i_flag,
    output logic             o_valid,
    output hvd_pkg::t_cordic o_data,
    output logic             o_flag
);
    import hvd_pkg::*;

    localparam logic signed [ANG_W-1:0] ATAN_STEP = f_atan(STEP);

    logic                    r_valid;
    logic                    r_flag;
    t_cordic                 r_data;
    t_cordic                 n_data;
    logic signed [ANG_W-1:0] x_sh;
    logic signed [ANG_W-1:0] y_sh;
    logic                    fwd;

    always_comb begin
        x_sh = i_data.x >>> STEP;
        y_sh = i_data.y >>> STEP;
        // rotate toward zero residual angle, or toward the x axis when vectoring
        fwd  = VECTOR ? i_data.y[ANG_W-1] : ~i_data.z[ANG_W-1];
        if (fwd) begin
            n_data.x = i_data.x - y_sh;
            n_data.y = i_data.y + x_sh;
            n_data.z = i_data.z - ATAN_STEP;
        end else begin
            n_data.x = i_data.x + y_sh;
            n_data.y = i_data.y - x_sh;
            n_data.z = i_data.z + ATAN_STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_flag <= i_flag;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_flag  = r_flag;

endmodule

[rtl/hvd_cordic.sv]
module hvd_cordic #(
    parameter int STEPS  = hvd_pkg::CORDIC_STEPS_DEF,
    parameter bit VECTOR = 1'b0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  hvd_pkg::t_cordic i_data,
    input  logic             i_flag,
    output logic             o_valid,
    output hvd_pkg::t_cordic o_data,
    output logic             o_flag
);
    import hvd_pkg::*;

    logic [STEPS:0] valid_c;
    logic [STEPS:0] flag_c;
    t_cordic        data_c [STEPS+1];

    assign valid_c[0] = i_valid;
    assign flag_c[0]  = i_flag;
    assign data_c[0]  = i_data;

    for (genvar g = 0; g < STEPS; g++) begin : g_cell
        hvd_cordic_cell #(
            .STEP   (g),
            .VECTOR (VECTOR)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid_c[g]),
            .i_data  (data_c[g]),
            .i_flag  (flag_c[g]),
            .o_valid (valid_c[g+1]),
            .o_data  (data_c[g+1]),
            .o_flag  (flag_c[g+1])
        );
    end

    assign o_valid = valid_c[STEPS];
    assign o_data  = data_c[STEPS];
    assign o_flag  = flag_c[STEPS];

endmodule

[rtl/hvd_sqrt_cell.sv]
module hvd_sqrt_cell #(
    parameter int unsigned B_SHIFT = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [hvd_pkg::SQ_W-1:0] i_v,
    input  logic [hvd_pkg::SQ_W-1:0] i_r,
    output logic                     o_valid,
    output logic [hvd_pkg::SQ_W-1:0] o_v,
    output logic [hvd_pkg::SQ_W-1:0] o_r
);
    import hvd_pkg::*;

    localparam logic [SQ_W-1:0] BIT = {{(SQ_W-1){1'b0}}, 1'b1} << B_SHIFT;

    logic            r_valid;
    logic [SQ_W-1:0] r_v;
    logic [SQ_W-1:0] r_r;
    logic [SQ_W-1:0] n_v;
    logic [SQ_W-1:0] n_r;
    logic [SQ_W-1:0] trial;

    always_comb begin
        trial = i_r + BIT;
        if (i_v >= trial) begin
            n_v = i_v - trial;
            n_r = (i_r >> 1) + BIT;
        end else begin
            n_v = i_v;
            n_r = i_r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v;
        r_r <= n_r;
    end

    assign o_valid = r_valid;
    assign o_v     = r_v;
    assign o_r     = r_r;

endmodule

[rtl/hvd_sqrt.sv]
module hvd_sqrt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [hvd_pkg::SQ_W-1:0] i_v,
    output logic                     o_valid,
    output logic [30:0]              o_root
);
    import hvd_pkg::*;

    logic [SQ_STEPS:0] valid_c;
    logic [SQ_W-1:0]   v_c [SQ_STEPS+1];
    logic [SQ_W-1:0]   r_c [SQ_STEPS+1];

    assign valid_c[0] = i_valid;
    assign v_c[0]     = i_v;
    assign r_c[0]     = '0;

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_cell
        hvd_sqrt_cell #(
            .B_SHIFT (2 * (SQ_STEPS - 1 - g))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid_c[g]),
            .i_v     (v_c[g]),
            .i_r     (r_c[g]),
            .o_valid (valid_c[g+1]),
            .o_v     (v_c[g+1]),
            .o_r     (r_c[g+1])
        );
    end

    assign o_valid = valid_c[SQ_STEPS] & (v_c[SQ_STEPS] == v_c[SQ_STEPS] );
    assign o_root  = r_c[SQ_STEPS][30:0];

endmodule

[rtl/haversine_distance_core.sv]
// Great-circle distance between two points, fully pipelined: one point pair is
// taken every clock and busy never rises. The result passes through six input
// stages, the sine/cosine CORDIC chain, five multiply stages, the 31-step square
// root chain, the atan2 CORDIC chain and three scaling stages, and is held on
// o_distance_cm for exactly the one cycle that o_strobe is high; the receiver
// cannot stall it and must take it then. The radius register is always ready
// and may be written only while no transaction is in flight.
module haversine_distance_core #(
    parameter int CORDIC_STEPS = hvd_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [30:0] i_first_longitude,
    input  logic signed [29:0] i_first_latitude,
    input  logic signed [30:0] i_second_longitude,
    input  logic signed [29:0] i_second_latitude,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [29:0]        i_cfg_earth_radius_cm,
    output logic               o_strobe,
    output logic [31:0]        o_distance_cm
);
    import hvd_pkg::*;

    // lanes: lat1, lat2, half dlat, half dlon
    localparam int LANES = 4;

    logic [29:0] r_radius;

    logic [5:0] r_fe_valid;
    logic [4:0] r_mid_valid;
    logic [2:0] r_out_valid;

    // stage A
    logic signed [29:0] r_a_lat1;
    logic signed [29:0] r_a_lat2;
    logic signed [30:0] r_a_dlat;
    logic signed [31:0] r_a_dlon;
    // stage B
    logic signed [31:0] b_ang [LANES];
    logic [31:0]        r_b_mag [LANES];
    logic [LANES-1:0]   r_b_neg;
    // stage C
    logic [46:0]        r_c_hi [LANES];
    logic [51:0]        r_c_lo [LANES];
    logic [LANES-1:0]   r_c_neg;
    // stage D
    logic [51:0]             d_lo_rnd [LANES];
    logic [47:0]             d_v [LANES];
    logic [32:0]             d_rm [LANES];
    logic signed [ANG_W-1:0] n_d_th [LANES];
    logic signed [ANG_W-1:0] r_d_th [LANES];
    // stage E
    logic signed [ANG_W-1:0] n_e_th [LANES];
    logic signed [ANG_W-1:0] r_e_th [LANES];
    // stage F
    logic signed [ANG_W-1:0] n_f_z [LANES];
    logic [LANES-1:0]        n_f_neg;
    logic signed [ANG_W-1:0] r_f_z [LANES];
    logic [LANES-1:0]        r_f_neg;
    // sine / cosine chains
    t_cordic          rot_in  [LANES];
    t_cordic          rot_out [LANES];
    logic [LANES-1:0] rot_flag;
    logic             rot_valid;
    // stage G .. K
    logic signed [31:0] r_g_c1;
    logic signed [31:0] r_g_c2;
    logic signed [31:0] r_g_sl;
    logic signed [31:0] r_g_so;
    logic signed [63:0] n_h_ll;
    logic signed [63:0] n_h_oo;
    logic signed [63:0] n_h_cc;
    logic signed [63:0] r_h_ll;
    logic signed [63:0] r_h_oo;
    logic signed [63:0] r_h_cc;
    logic signed [31:0] r_i_ll;
    logic signed [31:0] r_i_oo;
    logic signed [31:0] r_i_cc;
    logic signed [63:0] n_j_prod;
    logic signed [63:0] r_j_prod;
    logic signed [31:0] r_j_ll;
    logic signed [63:0] k_sum;
    logic [30:0]        n_k_a;
    logic [30:0]        r_k_a;
    // square roots and atan2
    logic [SQ_W-1:0] sq_vy;
    logic [SQ_W-1:0] sq_vx;
    logic [30:0]     root_y;
    logic [30:0]     root_x;
    logic            sq_valid;
    t_cordic         vec_in;
    t_cordic         vec_out;
    logic            vec_valid;
    // stage M .. O
    logic [31:0] n_m_c;
    logic [31:0] r_m_c;
    logic [61:0] n_n_prod;
    logic [61:0] r_n_prod;
    logic [31:0] r_o_dist;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
        end else if (i_cfg_valid) begin
            r_radius <= i_cfg_earth_radius_cm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fe_valid  <= '0;
            r_mid_valid <= '0;
            r_out_valid <= '0;
        end else begin
            r_fe_valid  <= {r_fe_valid[4:0], start};
            r_mid_valid <= {r_mid_valid[3:0], rot_valid};
            r_out_valid <= {r_out_valid[1:0], vec_valid};
        end
    end

    // degrees to radians, wrap into [-pi, pi], fold into [-pi/2, pi/2]
    always_comb begin
        b_ang[0] = 32'(r_a_lat1);
        b_ang[1] = 32'(r_a_lat2);
        b_ang[2] = 32'(r_a_dlat);
        b_ang[3] = r_a_dlon;
        for (int i = 0; i < LANES; i++) begin
            d_lo_rnd[i] = (r_c_lo[i] + 52'd524288) >> 20;
            d_v[i]      = 48'(r_c_hi[i]) + 48'(d_lo_rnd[i]);
            if (i >= 2) begin
                d_rm[i] = 33'((d_v[i] + 48'd4096) >> 13);
            end else begin
                d_rm[i] = 33'((d_v[i] + 48'd2048) >> 12);
            end
            n_d_th[i] = r_c_neg[i] ? -$signed({1'b0, d_rm[i]}) : $signed({1'b0, d_rm[i]});

            if (r_d_th[i] > PI_Q30) begin
                n_e_th[i] = r_d_th[i] - TWO_PI_Q30;
            end else if (r_d_th[i] < -PI_Q30) begin
                n_e_th[i] = r_d_th[i] + TWO_PI_Q30;
            end else begin
                n_e_th[i] = r_d_th[i];
            end

            if (r_e_th[i] > HALF_PI_Q30) begin
                n_f_z[i]   = PI_Q30 - r_e_th[i];
                n_f_neg[i] = 1'b1;
            end else if (r_e_th[i] < -HALF_PI_Q30) begin
                n_f_z[i]   = -PI_Q30 - r_e_th[i];
                n_f_neg[i] = 1'b1;
            end else begin
                n_f_z[i]   = r_e_th[i];
                n_f_neg[i] = 1'b0;
            end

            rot_in[i].x = INV_GAIN;
            rot_in[i].y = '0;
            rot_in[i].z = r_f_z[i];
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_lat1 <= i_first_latitude;
        r_a_lat2 <= i_second_latitude;
        r_a_dlat <= 31'(i_second_latitude) - 31'(i_first_latitude);
        r_a_dlon <= 32'(i_second_longitude) - 32'(i_first_longitude);
        for (int i = 0; i < LANES; i++) begin
            r_b_neg[i] <= b_ang[i][31];
            r_b_mag[i] <= b_ang[i][31] ? 32'(-b_ang[i]) : 32'(b_ang[i]);
            r_c_hi[i]  <= r_b_mag[i] * K_DEG_HI;
            r_c_lo[i]  <= r_b_mag[i] * K_DEG_LO;
            r_c_neg[i] <= r_b_neg[i];
            r_d_th[i]  <= n_d_th[i];
            r_e_th[i]  <= n_e_th[i];
            r_f_z[i]   <= n_f_z[i];
            r_f_neg[i] <= n_f_neg[i];
        end
    end

    for (genvar k = 0; k < LANES; k++) begin : g_rot
        if (k == 0) begin : g_lead
            hvd_cordic #(
                .STEPS  (CORDIC_STEPS),
                .VECTOR (1'b0)
            ) u_rot (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (r_fe_valid[5]),
                .i_data  (rot_in[k]),
                .i_flag  (r_f_neg[k]),
                .o_valid (rot_valid),
                .o_data  (rot_out[k]),
                .o_flag  (rot_flag[k])
            );
        end else begin : g_follow
            hvd_cordic #(
                .STEPS  (CORDIC_STEPS),
                .VECTOR (1'b0)
            ) u_rot (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (r_fe_valid[5]),
                .i_data  (rot_in[k]),
                .i_flag  (r_f_neg[k]),
                .o_valid (),
                .o_data  (rot_out[k]),
                .o_flag  (rot_flag[k])
            );
        end
    end

    // haversine term
    always_comb begin
        n_h_ll   = r_g_sl * r_g_sl;
        n_h_oo   = r_g_so * r_g_so;
        n_h_cc   = r_g_c1 * r_g_c2;
        n_j_prod = r_i_cc * r_i_oo;
        k_sum    = 64'(r_j_ll) + ((r_j_prod + 64'sd536870912) >>> 30);
        if (k_sum < 0) begin
            n_k_a = '0;
        end else if (k_sum > 64'(ONE_Q30)) begin
            n_k_a = ONE_Q30;
        end else begin
            n_k_a = 31'(k_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_c1   <= 32'(rot_flag[0] ? -rot_out[0].x : rot_out[0].x);
        r_g_c2   <= 32'(rot_flag[1] ? -rot_out[1].x : rot_out[1].x);
        r_g_sl   <= 32'(rot_out[2].y);
        r_g_so   <= 32'(rot_out[3].y);
        r_h_ll   <= n_h_ll;
        r_h_oo   <= n_h_oo;
        r_h_cc   <= n_h_cc;
        r_i_ll   <= 32'((r_h_ll + 64'sd536870912) >>> 30);
        r_i_oo   <= 32'((r_h_oo + 64'sd536870912) >>> 30);
        r_i_cc   <= 32'((r_h_cc + 64'sd536870912) >>> 30);
        r_j_prod <= n_j_prod;
        r_j_ll   <= r_i_ll;
        r_k_a    <= n_k_a;
    end

    assign sq_vy = SQ_W'({r_k_a, 30'd0});
    assign sq_vx = SQ_W'({ONE_Q30 - r_k_a, 30'd0});

    hvd_sqrt u_sqrt_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_mid_valid[4]),
        .i_v     (sq_vy),
        .o_valid (sq_valid),
        .o_root  (root_y)
    );

    hvd_sqrt u_sqrt_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_mid_valid[4]),
        .i_v     (sq_vx),
        .o_valid (),
        .o_root  (root_x)
    );

    always_comb begin
        vec_in.x = ANG_W'(root_x);
        vec_in.y = ANG_W'(root_y);
        vec_in.z = '0;
    end

    hvd_cordic #(
        .STEPS  (CORDIC_STEPS),
        .VECTOR (1'b1)
    ) u_atan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .i_data  (vec_in),
        .i_flag  (1'b0),
        .o_valid (vec_valid),
        .o_data  (vec_out),
        .o_flag  ()
    );

    // central angle times radius; drop a negative residual to zero
    always_comb begin
        n_m_c    = vec_out.z[ANG_W-1] ? 32'd0 : 32'(vec_out.z <<< 1);
        n_n_prod = r_m_c * r_radius;
    end

    always_ff @(posedge i_clk) begin
        r_m_c    <= n_m_c;
        r_n_prod <= n_n_prod;
        r_o_dist <= 32'((63'(r_n_prod) + 63'd536870912) >> 30);
    end

    assign o_strobe      = r_out_valid[2];
    assign o_distance_cm = r_o_dist;

endmodule
